@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/bacl_pkg.sv @@
package bacl_pkg;

  localparam int unsigned AdcW     = 12;
  localparam int unsigned RefW     = 13;
  localparam int unsigned RatW     = 12;
  localparam int unsigned RatFracW = 8;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned MvW      = 16;
  localparam int unsigned PctW     = 7;

  localparam int unsigned AdcMaxDefault = 4095;

  localparam logic [MvW-1:0] MvSat      = 16'hFFFF;
  localparam logic [MvW-1:0] ChargingMv = 16'd4200;

  // Discharge curve, top point first.
  localparam int unsigned CurvePoints = 11;
  localparam int unsigned Segments    = CurvePoints - 1;
  localparam logic [MvW-1:0] CurveMv [CurvePoints] = '{
    16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3800, 16'd3700,
    16'd3600, 16'd3500, 16'd3400, 16'd3300, 16'd3000
  };
  localparam logic [PctW-1:0] CurvePct [CurvePoints] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd0
  };

  // Per segment: span_pct * (2^16 / span_mv + 1); d * coef >> 16 equals
  // floor(d * span_pct / span_mv) over each segment's range.
  localparam int unsigned CoefShift = 16;
  localparam int unsigned CoefW     = 13;
  localparam int unsigned SegDW     = 9;
  localparam logic [CoefW-1:0] CurveCoef [Segments] = '{
    13'd6560, 13'd6560, 13'd6560, 13'd6560, 13'd6560,
    13'd6560, 13'd6560, 13'd6560, 13'd6560, 13'd2190
  };

  // Configuration register map.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgAdcRef  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDivRat  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLowThr  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCritThr = 2'd3;

  localparam logic [RefW-1:0] AdcRefReset  = 13'd3300;
  localparam logic [RatW-1:0] DivRatReset  = 12'd512;
  localparam logic [ThrW-1:0] LowThrReset  = 16'd3400;
  localparam logic [ThrW-1:0] CritThrReset = 16'd3200;

  typedef struct packed {
    logic [RefW-1:0] adc_reference_mv;
    logic [RatW-1:0] divider_ratio_q8;
    logic [ThrW-1:0] low_threshold_mv;
    logic [ThrW-1:0] critical_threshold_mv;
  } bacl_cfg_t;

  typedef struct packed {
    logic low;
    logic critical;
    logic charging;
  } bacl_flags_t;

endpackage

@@ rtl/bacl_if.sv @@
interface bacl_sample_if;
  import bacl_pkg::*;
  logic            valid;
  logic            ready;
  logic [AdcW-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface bacl_mv_if;
  import bacl_pkg::*;
  logic           valid;
  logic           ready;
  logic [MvW-1:0] battery_mv;
  modport source (output valid, output battery_mv, input ready);
  modport sink (input valid, input battery_mv, output ready);
endinterface

interface bacl_level_if;
  import bacl_pkg::*;
  logic            valid;
  logic            ready;
  logic [MvW-1:0]  battery_mv;
  logic [PctW-1:0] charge_percent;
  logic            low_flag;
  logic            critical_flag;
  logic            charging_flag;
  modport source (output valid, output battery_mv, output charge_percent,
                  output low_flag, output critical_flag, output charging_flag,
                  input ready);
  modport sink (input valid, input battery_mv, input charge_percent,
                input low_flag, input critical_flag, input charging_flag,
                output ready);
endinterface

@@ rtl/bacl_volt.sv @@
`include "assert_macros.svh"

// Sample to battery millivolts, five stages:
// product, reciprocal multiply, quotient check product, correction, ratio + saturate.
module bacl_volt #(
  parameter int unsigned AdcMax = bacl_pkg::AdcMaxDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  bacl_pkg::bacl_cfg_t cfg,
  bacl_sample_if.sink         up,
  bacl_mv_if.source           down
);
  import bacl_pkg::*;

  localparam int unsigned Stages = 5;
  localparam int unsigned ProdW  = AdcW + RefW;
  localparam longint unsigned RecipM = (64'd1 << ProdW) / AdcMax;
  localparam int unsigned MW     = $clog2(RecipM + 1);
  localparam longint unsigned QMax = ((64'd1 << ProdW) - 1) / AdcMax;
  localparam int unsigned QW     = $clog2(QMax + 1);
  localparam int unsigned BatW   = QW + RatW;
  localparam int unsigned ShW    = BatW - RatFracW;
  localparam int unsigned ScW    = (ShW > MvW) ? ShW : MvW;

  logic [Stages-1:0] vld;
  logic [Stages:0]   st_ready;

  logic [ProdW-1:0]    s1_prod;
  logic [ProdW-1:0]    s2_prod;
  logic [QW-1:0]       s2_q0;
  logic [ProdW-1:0]    s3_prod;
  logic [ProdW-1:0]    s3_qd;
  logic [QW-1:0]       s3_q0;
  logic [QW-1:0]       s4_pin;
  logic [MvW-1:0]      s5_mv;

  logic [ProdW+MW-1:0] recip_prod;
  logic [ProdW-1:0]    rem;
  logic [BatW-1:0]     bat;
  logic [ScW-1:0]      bat_sc;

  // a stage takes new data when empty or when the one after it moves on
  always_comb begin
    st_ready[Stages] = down.ready;
    for (int k = Stages - 1; k >= 0; k--) begin
      st_ready[k] = !vld[k] || st_ready[k+1];
    end
  end

  assign up.ready        = st_ready[0];
  assign down.valid      = vld[Stages-1];
  assign down.battery_mv = s5_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (st_ready[0]) begin
        vld[0] <= up.valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (st_ready[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign recip_prod = (ProdW+MW)'(s1_prod) * (ProdW+MW)'(RecipM);
  assign rem        = s3_prod - s3_qd;
  assign bat        = BatW'(s4_pin) * BatW'(cfg.divider_ratio_q8);
  assign bat_sc     = ScW'(bat >> RatFracW);

  always_ff @(posedge clk) begin
    if (st_ready[0]) begin
      s1_prod <= ProdW'(up.adc_sample) * ProdW'(cfg.adc_reference_mv);
    end
    if (st_ready[1]) begin
      s2_prod <= s1_prod;
      s2_q0   <= QW'(recip_prod >> ProdW);
    end
    if (st_ready[2]) begin
      s3_prod <= s2_prod;
      s3_q0   <= s2_q0;
      s3_qd   <= ProdW'(s2_q0) * ProdW'(AdcMax);
    end
    if (st_ready[3]) begin
      s4_pin <= (rem >= ProdW'(AdcMax)) ? s3_q0 + 1'b1 : s3_q0;
    end
    if (st_ready[4]) begin
      s5_mv <= (bat_sc > ScW'(MvSat)) ? MvSat : MvW'(bat_sc);
    end
  end

  // reciprocal estimate is never more than one short
  `ASSERT_NOW(a_rem_range, clk, rst, vld[2],
              (s3_qd <= s3_prod) && (rem < ProdW'(2 * AdcMax)))
  `ASSERT_NEXT(a_vld_advance, clk, rst, vld[0] && st_ready[1], vld[1])

endmodule

@@ rtl/bacl_pct.sv @@
`include "assert_macros.svh"

// Millivolts to charge percentage and flags: segment select, then interpolation.
module bacl_pct (
  input  logic                clk,
  input  logic                rst,
  input  bacl_pkg::bacl_cfg_t cfg,
  bacl_mv_if.sink             up,
  bacl_level_if.source        down
);
  import bacl_pkg::*;

  localparam int unsigned Stages = 2;
  localparam int unsigned IpW    = SegDW + CoefW;

  logic [Stages-1:0] vld;
  logic [Stages:0]   st_ready;

  logic [PctW-1:0]  base_next;
  logic [SegDW-1:0] d_next;
  logic [CoefW-1:0] coef_next;
  bacl_flags_t      flags_next;

  logic [MvW-1:0]   a_mv;
  logic [PctW-1:0]  a_base;
  logic [SegDW-1:0] a_d;
  logic [CoefW-1:0] a_coef;
  bacl_flags_t      a_flags;

  logic [IpW-1:0]   ip_prod;

  logic [MvW-1:0]   b_mv;
  logic [PctW-1:0]  b_pct;
  bacl_flags_t      b_flags;

  always_comb begin
    st_ready[Stages] = down.ready;
    for (int k = Stages - 1; k >= 0; k--) begin
      st_ready[k] = !vld[k] || st_ready[k+1];
    end
  end

  assign up.ready = st_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (st_ready[0]) begin
        vld[0] <= up.valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (st_ready[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // top segment wins on a shared boundary; both give the point's value
  always_comb begin
    base_next = '0;
    d_next    = '0;
    coef_next = '0;
    if (up.battery_mv >= CurveMv[0]) begin
      base_next = CurvePct[0];
    end else if (up.battery_mv > CurveMv[CurvePoints-1]) begin
      for (int i = Segments - 1; i >= 0; i--) begin
        if (up.battery_mv >= CurveMv[i+1]) begin
          base_next = CurvePct[i+1];
          d_next    = SegDW'(up.battery_mv - CurveMv[i+1]);
          coef_next = CurveCoef[i];
        end
      end
    end
    flags_next.low      = up.battery_mv < cfg.low_threshold_mv;
    flags_next.critical = up.battery_mv < cfg.critical_threshold_mv;
    flags_next.charging = up.battery_mv > ChargingMv;
  end

  assign ip_prod = IpW'(a_d) * IpW'(a_coef);

  always_ff @(posedge clk) begin
    if (st_ready[0]) begin
      a_mv    <= up.battery_mv;
      a_base  <= base_next;
      a_d     <= d_next;
      a_coef  <= coef_next;
      a_flags <= flags_next;
    end
    if (st_ready[1]) begin
      b_mv    <= a_mv;
      b_pct   <= a_base + PctW'(ip_prod >> CoefShift);
      b_flags <= a_flags;
    end
  end

  assign down.valid          = vld[Stages-1];
  assign down.battery_mv     = b_mv;
  assign down.charge_percent = b_pct;
  assign down.low_flag       = b_flags.low;
  assign down.critical_flag  = b_flags.critical;
  assign down.charging_flag  = b_flags.charging;

  `ASSERT_NOW(a_pct_range, clk, rst, vld[1], b_pct <= CurvePct[0])
  `ASSERT_NOW(a_pct_ends, clk, rst, vld[1],
              (!b_flags.charging || b_pct == CurvePct[0]) &&
              (b_mv > CurveMv[CurvePoints-1] || b_pct == '0))

endmodule

@@ rtl/battery_adc_to_charge_level.sv @@
// Pipeline: a transferred sample passes through five voltage stages, segment select and
//   the interpolation/output register before its result leaves the block.
// Throughput: one sample per cycle; every stage has its own valid bit, so a stall on
//   the result side only holds the stages that are full.
// Reset: synchronous, active high; empties the pipeline and loads the register defaults.
`include "assert_macros.svh"

module battery_adc_to_charge_level #(
  parameter int unsigned AdcMax = bacl_pkg::AdcMaxDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [bacl_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bacl_pkg::CfgDataW-1:0]   cfg_data,
  bacl_sample_if.sink                     adc,
  bacl_level_if.source                    level
);
  import bacl_pkg::*;

  // Configuration. The user is to write it only while no transfer is in flight (the block does
  // not enforce this), so the stages read it directly without carrying a copy along.
  bacl_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_reference_mv      <= AdcRefReset;
      cfg.divider_ratio_q8      <= DivRatReset;
      cfg.low_threshold_mv      <= LowThrReset;
      cfg.critical_threshold_mv <= CritThrReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CfgAdcRef:  cfg.adc_reference_mv      <= cfg_data[RefW-1:0];
        CfgDivRat:  cfg.divider_ratio_q8      <= cfg_data[RatW-1:0];
        CfgLowThr:  cfg.low_threshold_mv      <= cfg_data[ThrW-1:0];
        CfgCritThr: cfg.critical_threshold_mv <= cfg_data[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Voltage path: sample * vref / AdcMax (reciprocal multiply with one
  // correction step), then the Q4.8 divider ratio with saturation.
  bacl_mv_if mv_ch ();

  bacl_volt #(
    .AdcMax (AdcMax)
  ) u_volt (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .up   (adc),
    .down (mv_ch)
  );

  // Curve lookup and flags; its last stage is the output register.
  bacl_pct u_pct (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .up   (mv_ch),
    .down (level)
  );

  // Flag consistency against the live thresholds at the output.
  `ASSERT_NOW(a_flag_order, clk, rst,
              level.valid && (cfg.critical_threshold_mv <= cfg.low_threshold_mv),
              !level.critical_flag || level.low_flag)

endmodule

@@ verif/battery_adc_to_charge_level_tb.sv @@
`timescale 1ns / 1ps

module battery_adc_to_charge_level_tb;
  import bacl_pkg::*;

  // Cycles with no transfer of any kind before the run is declared hung.
  localparam int unsigned HangLimit = 2000;
  // Closing wait: covers the pipeline depth with a little margin.
  localparam int unsigned TailCycles = 12;
  localparam int unsigned PhaseItems = 195;
  localparam int unsigned RandPhases = 8;

  // One charge-level result, field for field as it leaves the block.
  typedef struct packed {
    logic [MvW-1:0]  mv;
    logic [PctW-1:0] pct;
    logic            low;
    logic            crit;
    logic            chg;
  } level_t;

  // Directed row: register contents it wants, the sample, and a result typed in by
  // hand where it is obvious (known = 0 leaves the row to the predictor).
  typedef struct packed {
    logic [CfgDataW-1:0] vref;
    logic [CfgDataW-1:0] ratio;
    logic [CfgDataW-1:0] low;
    logic [CfgDataW-1:0] crit;
    logic [AdcW-1:0]     sample;
    logic                known;
    level_t              res;
  } dir_row_t;

  localparam int unsigned DirRows = 23;
  localparam dir_row_t DirTab [DirRows] = '{
    // reset registers: zero sample and full scale
    '{16'd3300, 16'd512, 16'd3400, 16'd3200, 12'd0,    1'b1, '{16'd0, 7'd0, 1'b1, 1'b1, 1'b0}},
    '{16'd3300, 16'd512, 16'd3400, 16'd3200, 12'd4095,
      1'b1, '{16'd6600, 7'd100, 1'b0, 1'b0, 1'b1}},
    '{16'd3300, 16'd512, 16'd3400, 16'd3200, 12'd2048, 1'b0, '0},
    // unity pin scale, ratio 2.0: battery_mv = 2 * sample, at, between and above curve points
    '{16'd4095, 16'd512, 16'd3400, 16'd3200, 12'd2100,
      1'b1, '{16'd4200, 7'd100, 1'b0, 1'b0, 1'b0}},
    '{16'd4095, 16'd512, 16'd3400, 16'd3200, 12'd2101,
      1'b1, '{16'd4202, 7'd100, 1'b0, 1'b0, 1'b1}},
    '{16'd4095, 16'd512, 16'd3400, 16'd3200, 12'd2050,
      1'b1, '{16'd4100, 7'd90, 1'b0, 1'b0, 1'b0}},
    '{16'd4095, 16'd512, 16'd3400, 16'd3200, 12'd1500,
      1'b1, '{16'd3000, 7'd0, 1'b1, 1'b1, 1'b0}},
    '{16'd4095, 16'd512, 16'd3400, 16'd3200, 12'd1501, 1'b0, '0},
    '{16'd4095, 16'd512, 16'd3400, 16'd3200, 12'd1650,
      1'b1, '{16'd3300, 7'd10, 1'b1, 1'b0, 1'b0}},
    '{16'd4095, 16'd512, 16'd3400, 16'd3200, 12'd1700,
      1'b1, '{16'd3400, 7'd20, 1'b0, 1'b0, 1'b0}},
    '{16'd4095, 16'd512, 16'd3400, 16'd3200, 12'd1600, 1'b0, '0},
    '{16'd4095, 16'd512, 16'd3400, 16'd3200, 12'd1599, 1'b0, '0},
    '{16'd4095, 16'd512, 16'd3400, 16'd3200, 12'd1975, 1'b0, '0},
    '{16'd4095, 16'd512, 16'd3400, 16'd3200, 12'd4095,
      1'b1, '{16'd8190, 7'd100, 1'b0, 1'b0, 1'b1}},
    // zero reference
    '{16'd0,    16'd512, 16'd3400, 16'd3200, 12'd4095, 1'b1, '{16'd0, 7'd0, 1'b1, 1'b1, 1'b0}},
    '{16'd0,    16'd512, 16'd3400, 16'd3200, 12'd0,    1'b1, '{16'd0, 7'd0, 1'b1, 1'b1, 1'b0}},
    // zero divider ratio
    '{16'd3300, 16'd0,   16'd3400, 16'd3200, 12'd4095, 1'b1, '{16'd0, 7'd0, 1'b1, 1'b1, 1'b0}},
    // all-ones writes, masked to width: saturation, thresholds at top
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd4095,
      1'b1, '{16'hFFFF, 7'd100, 1'b0, 1'b0, 1'b1}},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd1,    1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd2048, 1'b0, '0},
    // thresholds at zero: low and critical flags never set
    '{16'd5000, 16'd256, 16'd0,    16'd0,    12'd0,    1'b1, '{16'd0, 7'd0, 1'b0, 1'b0, 1'b0}},
    '{16'd5000, 16'd256, 16'd0,    16'd0,    12'd4095,
      1'b1, '{16'd5000, 7'd100, 1'b0, 1'b0, 1'b1}},
    '{16'd5000, 16'd256, 16'd0,    16'd0,    12'd3354, 1'b0, '0}
  };

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  bacl_sample_if sample_ch ();
  bacl_level_if  level_ch ();

  battery_adc_to_charge_level uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adc       (sample_ch),
    .level     (level_ch)
  );

  // Local copy of the register file, held as the block should see it (masked).
  logic [RefW-1:0] vref_mv;
  logic [RatW-1:0] div_ratio;
  logic [ThrW-1:0] low_thr;
  logic [ThrW-1:0] crit_thr;

  level_t      pending_levels [$];
  int unsigned mismatch_cnt;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned quiet_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Sample -> pin mV -> battery mV (Q4.8, saturating) -> curve lookup and flags.
  function automatic level_t level_from_sample(input logic [AdcW-1:0] s);
    logic [31:0] pin;
    logic [31:0] bat;
    int          mv;
    int          k;
    bit          found;
    level_t      r;
    pin   = (32'(s) * 32'(vref_mv)) / 32'(AdcMaxDefault);
    bat   = (pin * 32'(div_ratio)) >> RatFracW;
    r.mv  = (bat > 32'hFFFF) ? 16'hFFFF : bat[MvW-1:0];
    mv    = int'(r.mv);
    found = 1'b0;
    if (mv >= int'(CurveMv[0])) begin
      r.pct = 7'd100;
    end else if (mv <= int'(CurveMv[CurvePoints-1])) begin
      r.pct = 7'd0;
    end else begin
      r.pct = 7'd0;
      // Scan from the top; the first segment whose lower point is reached wins.
      for (k = 0; k < CurvePoints - 1; k++) begin
        if (!found && mv >= int'(CurveMv[k+1])) begin
          r.pct = PctW'(int'(CurvePct[k+1]) +
                        ((mv - int'(CurveMv[k+1])) * (int'(CurvePct[k]) - int'(CurvePct[k+1])))
                        / (int'(CurveMv[k]) - int'(CurveMv[k+1])));
          found = 1'b1;
        end
      end
    end
    r.low  = (r.mv < low_thr);
    r.crit = (r.mv < crit_thr);
    r.chg  = (r.mv > ChargingMv);
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge, with the write enable dropped after the write edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CfgAdcRef:  vref_mv   = d[RefW-1:0];
      CfgDivRat:  div_ratio = d[RatW-1:0];
      CfgLowThr:  low_thr   = d[ThrW-1:0];
      CfgCritThr: crit_thr  = d[ThrW-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_all_regs(input logic [CfgDataW-1:0] d_ref, input logic [CfgDataW-1:0] d_rat,
                                input logic [CfgDataW-1:0] d_low, input logic [CfgDataW-1:0] d_crit);
    write_reg(CfgAdcRef, d_ref);
    write_reg(CfgDivRat, d_rat);
    write_reg(CfgLowThr, d_low);
    write_reg(CfgCritThr, d_crit);
  endtask

  // Entered and left at a falling edge. Random idle cycles first, then hold the
  // sample until it transfers; the expectation is queued at the transfer edge.
  task automatic send_sample(input logic [AdcW-1:0] s, input logic known, input level_t typed);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.adc_sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    pending_levels.push_back(known ? typed : level_from_sample(s));
    @(negedge clk);
  endtask

  // Stop feeding and let every outstanding result come out before touching registers.
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side back-pressure, redrawn every falling edge.
  always @(negedge clk) begin
    level_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Scoreboard: every result transfer must match the oldest queued expectation.
  always @(posedge clk) begin : level_check
    level_t got;
    level_t want;
    if (!rst && level_ch.valid && level_ch.ready) begin
      got = '{level_ch.battery_mv, level_ch.charge_percent, level_ch.low_flag,
              level_ch.critical_flag, level_ch.charging_flag};
      if (pending_levels.size() == 0) begin
        $display("%0t: result with nothing expected: mv=%0d pct=%0d low=%0b crit=%0b chg=%0b",
                 $time, got.mv, got.pct, got.low, got.crit, got.chg);
        mismatch_cnt++;
      end else begin
        want = pending_levels.pop_front();
        if (got !== want) begin
          $display("%0t: expected mv=%0d pct=%0d low=%0b crit=%0b chg=%0b,",
                   $time, want.mv, want.pct, want.low, want.crit, want.chg,
                   " actual mv=%0d pct=%0d low=%0b crit=%0b chg=%0b",
                   got.mv, got.pct, got.low, got.crit, got.chg);
          mismatch_cnt++;
        end
      end
    end
  end

  // Hang detector: any transfer or register write counts as progress.
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (sample_ch.valid && sample_ch.ready) ||
        (level_ch.valid && level_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("battery_adc_to_charge_level test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned    i;
    int unsigned    p;
    int unsigned    r;
    logic [AdcW-1:0] s;
    logic [CfgDataW-1:0] d_ref;
    logic [CfgDataW-1:0] d_rat;
    logic [CfgDataW-1:0] d_low;
    logic [CfgDataW-1:0] d_crit;

    // Every input known from time zero.
    rst                  = 1'b1;
    cfg_wr_en            = 1'b0;
    cfg_index            = CfgAdcRef;
    cfg_data             = '0;
    sample_ch.valid      = 1'b0;
    sample_ch.adc_sample = '0;
    level_ch.ready       = 1'b0;
    mismatch_cnt         = 0;
    quiet_cycles         = 0;
    src_idle_pct         = 0;
    snk_stall_pct        = 0;
    vref_mv              = AdcRefReset;
    div_ratio            = DivRatReset;
    low_thr              = LowThrReset;
    crit_thr             = CritThrReset;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table, back-to-back transfers. Registers only change once drained.
    for (i = 0; i < DirRows; i++) begin
      if (DirTab[i].vref[RefW-1:0] != vref_mv || DirTab[i].ratio[RatW-1:0] != div_ratio ||
          DirTab[i].low[ThrW-1:0] != low_thr || DirTab[i].crit[ThrW-1:0] != crit_thr) begin
        drain_results();
        write_all_regs(DirTab[i].vref, DirTab[i].ratio, DirTab[i].low, DirTab[i].crit);
      end
      send_sample(DirTab[i].sample, DirTab[i].known, DirTab[i].res);
    end

    // Random phases: cycle through the idle modes, fresh registers each phase.
    for (p = 0; p < RandPhases; p++) begin
      drain_results();
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 20; snk_stall_pct = 20; end
      endcase
      r = $urandom_range(99);
      if (p == RandPhases - 1) begin
        // Widest scale, thresholds at zero.
        d_ref = 16'hFFFF; d_rat = 16'hFFFF; d_low = '0; d_crit = '0;
      end else if (r < 65) begin
        // Settings that put most samples across the discharge curve.
        d_ref  = (r < 20) ? 16'd3300 : 16'($urandom_range(2500, 5000));
        d_rat  = 16'($urandom_range(300, 700));
        d_low  = 16'($urandom_range(2900, 4300));
        d_crit = 16'($urandom_range(2900, 4300));
        if (p == 4) begin
          d_low  = 16'hFFFF;
          d_crit = 16'hFFFF;
        end
      end else begin
        // Raw 16-bit writes; upper bits beyond each register are dropped.
        d_ref  = 16'($urandom);
        d_rat  = 16'($urandom);
        d_low  = 16'($urandom);
        d_crit = 16'($urandom);
      end
      write_all_regs(d_ref, d_rat, d_low, d_crit);

      for (i = 0; i < PhaseItems; i++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          case ($urandom_range(3))
            0: s = '0;
            1: s = 12'd1;
            2: s = 12'd4094;
            default: s = '1;
          endcase
        end else begin
          s = AdcW'($urandom_range(4095));
        end
        send_sample(s, 1'b0, '0);
      end
    end

    // Everything sent; wait for the last results, then a few more edges for strays.
    drain_results();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_cnt == 0 && pending_levels.size() == 0) begin
      $display("battery_adc_to_charge_level test passed");
    end else begin
      $display("battery_adc_to_charge_level test failed");
    end
    $finish;
  end

endmodule
